[hw/rtl/bas_pkg.sv]
package bas_pkg;

  localparam int SAMPLE_W = 8;
  localparam int COUNT_W  = 7;
  localparam int SUM_W    = 14;
  localparam int POS_W    = 6;
  localparam int DIV_W    = 4;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [SUM_W-1:0]    sum;
    logic                dropped;
    logic [SAMPLE_W-1:0] maxv;
    logic [SAMPLE_W-1:0] minv;
  } run_desc_t;

endpackage

[hw/rtl/byte_array_statistics_sorter_core.sv]
// Collects unsigned bytes, one per request, and on the request marked last
// emits the set in descending order with its maximum, minimum, truncated mean
// and median on every result. A request is taken at a rising edge with start
// high and busy low; each result shows for exactly one cycle under strobe and
// the receiver cannot hold it off. Bytes can be collected back to back while
// busy is low. After the last byte of an n-byte set, busy stays high through
// the mean division, then a ranking pass that reads every stored byte once per
// element through the sample store's single read port, then a read of the
// median, then the n results, one per cycle. Bytes beyond MAX_COUNT are
// dropped and flagged as overflow.
module byte_array_statistics_sorter_core #(
  parameter int MAX_COUNT = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [bas_pkg::SAMPLE_W-1:0] sample,
  input  logic                         last_sample,
  output logic                         strobe,
  output logic [bas_pkg::SAMPLE_W-1:0] sorted_value,
  output logic [bas_pkg::POS_W-1:0]    position,
  output logic [bas_pkg::SAMPLE_W-1:0] max_value,
  output logic [bas_pkg::SAMPLE_W-1:0] min_value,
  output logic [bas_pkg::SAMPLE_W-1:0] mean_value,
  output logic [bas_pkg::SAMPLE_W-1:0] median_value,
  output logic                         overflow,
  output logic                         last_result
);

  localparam int AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;

  logic                         accept;
  logic                         store_we;
  logic [AW-1:0]                store_waddr;
  logic [bas_pkg::SAMPLE_W-1:0] store_wdata;
  logic [AW-1:0]                store_raddr;
  logic [bas_pkg::SAMPLE_W-1:0] store_rdata;
  logic                         push;
  bas_pkg::run_desc_t           push_desc;
  logic                         pop;
  bas_pkg::run_desc_t           pop_desc;
  logic                         q_empty;
  logic                         back_active;

  // the store is shared, so a new set waits until the run has been emitted
  assign busy   = !q_empty || back_active;
  assign accept = start && !busy;

  bas_front #(
    .MAX_COUNT(MAX_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sample     (sample),
    .last_sample(last_sample),
    .store_we   (store_we),
    .store_waddr(store_waddr),
    .store_wdata(store_wdata),
    .push       (push),
    .push_desc  (push_desc)
  );

  bas_ram #(
    .WIDTH(bas_pkg::SAMPLE_W),
    .DEPTH(MAX_COUNT)
  ) u_sample_ram (
    .clk  (clk),
    .we   (store_we),
    .waddr(store_waddr),
    .wdata(store_wdata),
    .raddr(store_raddr),
    .rdata(store_rdata)
  );

  bas_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_desc(push_desc),
    .pop      (pop),
    .pop_desc (pop_desc),
    .empty    (q_empty)
  );

  bas_back #(
    .MAX_COUNT(MAX_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_desc      (pop_desc),
    .q_pop       (pop),
    .store_raddr (store_raddr),
    .store_rdata (store_rdata),
    .active      (back_active),
    .strobe      (strobe),
    .sorted_value(sorted_value),
    .position    (position),
    .max_value   (max_value),
    .min_value   (min_value),
    .mean_value  (mean_value),
    .median_value(median_value),
    .overflow    (overflow),
    .last_result (last_result)
  );

endmodule

[hw/rtl/bas_ram.sv]
module bas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/bas_queue.sv]
module bas_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bas_pkg::run_desc_t push_desc,
  input  logic               pop,
  output bas_pkg::run_desc_t pop_desc,
  output logic               empty
);

  bas_pkg::run_desc_t entries [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         fill;

  assign empty    = (fill == 2'd0);
  assign pop_desc = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && fill != 2'd2) begin
        entries[wr_ptr] <= push_desc;
        wr_ptr          <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      priority if ((push && fill != 2'd2) && !(pop && !empty)) begin
        fill <= fill + 2'd1;
      end else if (!(push && fill != 2'd2) && (pop && !empty)) begin
        fill <= fill - 2'd1;
      end else begin
        fill <= fill;
      end
    end
  end

endmodule

[hw/rtl/bas_front.sv]
module bas_front #(
  parameter int MAX_COUNT = 64
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               accept,
  input  logic [bas_pkg::SAMPLE_W-1:0]                       sample,
  input  logic                                               last_sample,
  output logic                                               store_we,
  output logic [(MAX_COUNT > 1 ? $clog2(MAX_COUNT) : 1)-1:0] store_waddr,
  output logic [bas_pkg::SAMPLE_W-1:0]                       store_wdata,
  output logic                                               push,
  output bas_pkg::run_desc_t                                 push_desc
);

  localparam int AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;

  logic [bas_pkg::COUNT_W-1:0]  count;
  logic [bas_pkg::SUM_W-1:0]    sum;
  logic                         dropped;
  logic [bas_pkg::SAMPLE_W-1:0] maxv;
  logic [bas_pkg::SAMPLE_W-1:0] minv;

  logic                         room;
  bas_pkg::run_desc_t           desc_next;

  assign room = (count < bas_pkg::COUNT_W'(MAX_COUNT));

  assign store_we    = accept && room;
  assign store_waddr = count[AW-1:0];
  assign store_wdata = sample;

  // collection state as it stands after this request
  always_comb begin
    desc_next.count   = count;
    desc_next.sum     = sum;
    desc_next.dropped = dropped;
    desc_next.maxv    = maxv;
    desc_next.minv    = minv;
    if (room) begin
      desc_next.count = count + bas_pkg::COUNT_W'(1);
      desc_next.sum   = sum + bas_pkg::SUM_W'(sample);
      if (count == '0 || sample > maxv) begin
        desc_next.maxv = sample;
      end
      if (count == '0 || sample < minv) begin
        desc_next.minv = sample;
      end
    end else begin
      desc_next.dropped = 1'b1;
    end
  end

  assign push      = accept && last_sample;
  assign push_desc = desc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum     <= '0;
      dropped <= 1'b0;
      maxv    <= '0;
      minv    <= '0;
    end else if (accept) begin
      if (last_sample) begin
        count   <= '0;
        sum     <= '0;
        dropped <= 1'b0;
      end else begin
        count   <= desc_next.count;
        sum     <= desc_next.sum;
        dropped <= desc_next.dropped;
        maxv    <= desc_next.maxv;
        minv    <= desc_next.minv;
      end
    end
  end

endmodule

[hw/rtl/bas_back.sv]
module bas_back #(
  parameter int MAX_COUNT = 64
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               q_empty,
  input  bas_pkg::run_desc_t                                 q_desc,
  output logic                                               q_pop,
  output logic [(MAX_COUNT > 1 ? $clog2(MAX_COUNT) : 1)-1:0] store_raddr,
  input  logic [bas_pkg::SAMPLE_W-1:0]                       store_rdata,
  output logic                                               active,
  output logic                                               strobe,
  output logic [bas_pkg::SAMPLE_W-1:0]                       sorted_value,
  output logic [bas_pkg::POS_W-1:0]                          position,
  output logic [bas_pkg::SAMPLE_W-1:0]                       max_value,
  output logic [bas_pkg::SAMPLE_W-1:0]                       min_value,
  output logic [bas_pkg::SAMPLE_W-1:0]                       mean_value,
  output logic [bas_pkg::SAMPLE_W-1:0]                       median_value,
  output logic                                               overflow,
  output logic                                               last_result
);

  localparam int AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_LOADI, S_SCAN0, S_SCAN, S_MED, S_MEDW, S_EMIT0, S_EMIT
  } state_t;

  state_t                       state;
  bas_pkg::run_desc_t           run;
  logic [bas_pkg::COUNT_W-1:0]  i;
  logic [bas_pkg::COUNT_W-1:0]  j;
  logic [bas_pkg::COUNT_W-1:0]  jr;
  logic [bas_pkg::COUNT_W-1:0]  rank;
  logic [bas_pkg::SAMPLE_W-1:0] cur;
  logic [bas_pkg::SAMPLE_W-1:0] median;
  logic [bas_pkg::SUM_W-1:0]    div_q;
  logic [bas_pkg::COUNT_W:0]    div_rem;
  logic [bas_pkg::DIV_W-1:0]    div_cnt;

  logic [bas_pkg::COUNT_W:0]    trial;
  logic                         trial_ge;
  logic                         rank_inc;
  logic [bas_pkg::COUNT_W-1:0]  rank_next;
  logic [bas_pkg::COUNT_W-1:0]  n_last;

  logic                         srt_we;
  logic [AW-1:0]                srt_waddr;
  logic [AW-1:0]                srt_raddr;
  logic [bas_pkg::SAMPLE_W-1:0] srt_rdata;

  bas_ram #(
    .WIDTH(bas_pkg::SAMPLE_W),
    .DEPTH(MAX_COUNT)
  ) u_sorted_ram (
    .clk  (clk),
    .we   (srt_we),
    .waddr(srt_waddr),
    .wdata(cur),
    .raddr(srt_raddr),
    .rdata(srt_rdata)
  );

  // restoring division step
  assign trial    = {div_rem[bas_pkg::COUNT_W-1:0], div_q[bas_pkg::SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, run.count});

  // rank counts larger elements and equal ones stored earlier
  assign rank_inc  = (store_rdata > cur) || ((store_rdata == cur) && (jr < i));
  assign rank_next = rank + bas_pkg::COUNT_W'(rank_inc);
  assign n_last    = run.count - bas_pkg::COUNT_W'(1);

  assign active      = (state != S_IDLE);
  assign q_pop       = (state == S_IDLE) && !q_empty;
  assign store_raddr = (state == S_LOADI) ? i[AW-1:0] : j[AW-1:0];
  assign srt_we      = (state == S_SCAN) && (jr == n_last);
  assign srt_waddr   = rank_next[AW-1:0];
  assign srt_raddr   = (state == S_MED) ? run.count[AW:1] : j[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            run     <= q_desc;
            div_q   <= q_desc.sum;
            div_rem <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          div_q   <= {div_q[bas_pkg::SUM_W-2:0], trial_ge};
          div_rem <= trial_ge ? (trial - {1'b0, run.count}) : trial;
          div_cnt <= div_cnt + bas_pkg::DIV_W'(1);
          if (div_cnt == bas_pkg::DIV_W'(bas_pkg::SUM_W - 1)) begin
            i     <= '0;
            state <= S_LOADI;
          end
        end
        S_LOADI: begin
          j     <= '0;
          state <= S_SCAN0;
        end
        S_SCAN0: begin
          cur   <= store_rdata;
          jr    <= '0;
          j     <= bas_pkg::COUNT_W'(1);
          rank  <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          rank <= rank_next;
          jr   <= j;
          j    <= j + bas_pkg::COUNT_W'(1);
          if (jr == n_last) begin
            i <= i + bas_pkg::COUNT_W'(1);
            if (i == n_last) begin
              state <= S_MED;
            end else begin
              state <= S_LOADI;
            end
          end
        end
        S_MED: begin
          state <= S_MEDW;
        end
        S_MEDW: begin
          median <= srt_rdata;
          j      <= '0;
          state  <= S_EMIT0;
        end
        S_EMIT0: begin
          jr    <= '0;
          j     <= bas_pkg::COUNT_W'(1);
          state <= S_EMIT;
        end
        S_EMIT: begin
          strobe       <= 1'b1;
          sorted_value <= srt_rdata;
          position     <= jr[bas_pkg::POS_W-1:0];
          max_value    <= run.maxv;
          min_value    <= run.minv;
          mean_value   <= div_q[bas_pkg::SAMPLE_W-1:0];
          median_value <= median;
          overflow     <= run.dropped;
          last_result  <= (jr == n_last);
          jr           <= j;
          j            <= j + bas_pkg::COUNT_W'(1);
          if (jr == n_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sim/byte_array_statistics_sorter_core_tb.sv]
`timescale 1ns / 1ps

module byte_array_statistics_sorter_core_tb;

  localparam int MAX_COUNT   = 64;
  localparam int RANDOM_REQS = 360;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [bas_pkg::SAMPLE_W-1:0] sorted;
    logic [bas_pkg::POS_W-1:0]    pos;
    logic [bas_pkg::SAMPLE_W-1:0] maxv;
    logic [bas_pkg::SAMPLE_W-1:0] minv;
    logic [bas_pkg::SAMPLE_W-1:0] meanv;
    logic [bas_pkg::SAMPLE_W-1:0] medv;
    logic                         ovf;
    logic                         fin;
  } ranked_byte_t;

  typedef struct packed {
    logic [bas_pkg::SAMPLE_W-1:0] smp;
    logic                         lst;
    logic                         typed;
  } stim_row_t;

  typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGES} spread_t;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic [bas_pkg::SAMPLE_W-1:0] sample;
  logic                         last_sample;
  logic                         strobe;
  logic [bas_pkg::SAMPLE_W-1:0] sorted_value;
  logic [bas_pkg::POS_W-1:0]    position;
  logic [bas_pkg::SAMPLE_W-1:0] max_value;
  logic [bas_pkg::SAMPLE_W-1:0] min_value;
  logic [bas_pkg::SAMPLE_W-1:0] mean_value;
  logic [bas_pkg::SAMPLE_W-1:0] median_value;
  logic                         overflow;
  logic                         last_result;

  byte_array_statistics_sorter_core #(
    .MAX_COUNT(MAX_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sample(sample),
    .last_sample(last_sample),
    .strobe(strobe),
    .sorted_value(sorted_value),
    .position(position),
    .max_value(max_value),
    .min_value(min_value),
    .mean_value(mean_value),
    .median_value(median_value),
    .overflow(overflow),
    .last_result(last_result)
  );

  // typed rows are single-byte sets: every statistic equals the byte
  stim_row_t directed [0:17] = '{
    '{8'd0,   1'b1, 1'b1},
    '{8'd255, 1'b1, 1'b1},
    '{8'd255, 1'b0, 1'b0},
    '{8'd0,   1'b1, 1'b0},
    '{8'd7,   1'b0, 1'b0},
    '{8'd7,   1'b0, 1'b0},
    '{8'd7,   1'b0, 1'b0},
    '{8'd7,   1'b1, 1'b0},
    '{8'd1,   1'b0, 1'b0},
    '{8'd2,   1'b0, 1'b0},
    '{8'd3,   1'b0, 1'b0},
    '{8'd4,   1'b0, 1'b0},
    '{8'd5,   1'b1, 1'b0},
    '{8'd128, 1'b0, 1'b0},
    '{8'd127, 1'b0, 1'b0},
    '{8'd200, 1'b1, 1'b0},
    '{8'd170, 1'b1, 1'b1},
    '{8'd85,  1'b1, 1'b1}
  };

  logic [bas_pkg::SAMPLE_W-1:0] held [MAX_COUNT];
  int                           held_n;
  logic [bas_pkg::SUM_W-1:0]    sum_acc;
  logic                         dropped;

  ranked_byte_t pending_ranks [$];
  ranked_byte_t head;
  int           fails;
  int           cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model of the block: store, running sum, drop flag, then the ranked run
  task automatic absorb_sample(input logic [bas_pkg::SAMPLE_W-1:0] smp, input logic lst,
                               input bit push);
    logic [bas_pkg::SAMPLE_W-1:0] ord [MAX_COUNT];
    logic [bas_pkg::SAMPLE_W-1:0] t;
    logic [bas_pkg::SAMPLE_W-1:0] meanv;
    ranked_byte_t                 r;
    int                           n, i, j;
    if (held_n < MAX_COUNT) begin
      held[held_n] = smp;
      held_n++;
      sum_acc = sum_acc + smp;
    end else begin
      dropped = 1'b1;
    end
    if (lst) begin
      n = held_n;
      for (i = 0; i < n; i++) ord[i] = held[i];
      for (i = 0; i < n - 1; i++) begin
        for (j = i + 1; j < n; j++) begin
          if (ord[j] > ord[i]) begin
            t      = ord[i];
            ord[i] = ord[j];
            ord[j] = t;
          end
        end
      end
      meanv = bas_pkg::SAMPLE_W'(int'(sum_acc) / n);
      if (push) begin
        for (i = 0; i < n; i++) begin
          r.sorted = ord[i];
          r.pos    = bas_pkg::POS_W'(i);
          r.maxv   = ord[0];
          r.minv   = ord[n-1];
          r.meanv  = meanv;
          r.medv   = ord[n/2];
          r.ovf    = dropped;
          r.fin    = (i == n - 1);
          pending_ranks.push_back(r);
        end
      end
      held_n  = 0;
      sum_acc = '0;
      dropped = 1'b0;
    end
  endtask

  // start is left high after acceptance so back-to-back requests keep it up
  task automatic issue(input logic [bas_pkg::SAMPLE_W-1:0] smp, input logic lst,
                       input int gap, input bit push);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    sample      <= smp;
    last_sample <= lst;
    do @(posedge clk); while (busy);
    absorb_sample(smp, lst, push);
  endtask

  function automatic logic [bas_pkg::SAMPLE_W-1:0] pick_sample(
      spread_t spread, logic [bas_pkg::SAMPLE_W-1:0] base);
    case (spread)
      SPREAD_NARROW: return base + bas_pkg::SAMPLE_W'($urandom_range(0, 3));
      SPREAD_EDGES:  return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      default:       return bas_pkg::SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_ranks.size() == 0) begin
        $error("result with nothing pending: sorted_value %0d position %0d",
               sorted_value, position);
        fails++;
      end else begin
        head = pending_ranks.pop_front();
        check_field("sorted_value", head.sorted, sorted_value);
        check_field("position", 8'(head.pos), 8'(position));
        check_field("max_value", head.maxv, max_value);
        check_field("min_value", head.minv, min_value);
        check_field("mean_value", head.meanv, mean_value);
        check_field("median_value", head.medv, median_value);
        check_field("overflow", 8'(head.ovf), 8'(overflow));
        check_field("last_result", 8'(head.fin), 8'(last_result));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int                           sent, setno, len, k, gap;
    bit                           quiet;
    spread_t                      spread;
    logic [bas_pkg::SAMPLE_W-1:0] base, v;
    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    sample      = '0;
    last_sample = 1'b0;
    held_n      = 0;
    sum_acc     = '0;
    dropped     = 1'b0;
    fails       = 0;
    cycles      = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[idx]) begin
      issue(directed[idx].smp, directed[idx].lst, $urandom_range(0, 12),
            !directed[idx].typed);
      if (directed[idx].typed)
        pending_ranks.push_back(ranked_byte_t'{directed[idx].smp, bas_pkg::POS_W'(0),
                                directed[idx].smp, directed[idx].smp,
                                directed[idx].smp, directed[idx].smp, 1'b0, 1'b1});
    end

    // mostly short sets; a full store and an overflowing one come early
    sent  = 0;
    setno = 0;
    while (sent < RANDOM_REQS) begin
      if (setno == 0)
        len = MAX_COUNT + $urandom_range(1, 4);
      else if (setno == 1)
        len = MAX_COUNT;
      else begin
        k = $urandom_range(0, 19);
        if (k == 0)      len = $urandom_range(MAX_COUNT, MAX_COUNT + 4);
        else if (k < 4)  len = $urandom_range(9, MAX_COUNT - 1);
        else             len = $urandom_range(1, 8);
      end
      spread = spread_t'($urandom_range(0, 2));
      base   = bas_pkg::SAMPLE_W'($urandom_range(0, 255));
      quiet  = ($urandom_range(0, 3) == 0);
      for (k = 0; k < len; k++) begin
        v   = pick_sample(spread, base);
        gap = quiet ? 0 : $urandom_range(0, 12);
        issue(v, k == len - 1, gap, 1'b1);
      end
      sent += len;
      setno++;
    end
    start <= 1'b0;

    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/bas_pkg.sv
hw/rtl/bas_ram.sv
hw/rtl/bas_queue.sv
hw/rtl/bas_front.sv
hw/rtl/bas_back.sv
hw/rtl/byte_array_statistics_sorter_core.sv
sim/byte_array_statistics_sorter_core_tb.sv
